@@ rtl/core/nmea_sentence_validator_assert.svh @@
// Assertion macros used by the checker module of the sentence validator.
// Depends on nothing; included by the checker file by its bare name.
`ifndef NMEA_SENTENCE_VALIDATOR_ASSERT_SVH
`define NMEA_SENTENCE_VALIDATOR_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define NSV_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define NSV_ASSERT_SAME(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

`endif

@@ rtl/core/nsv_pkg.sv @@
// Package for the sentence validator: character codes, field layout,
// the verdict type and the hex digit decoder. Depends on nothing.
package nsv_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int          POS_W    = 4;
    localparam logic [3:0]  POS_FULL = 4'd9;
    localparam logic [4:0]  HEX_NONE = 5'd16;

    // Bit positions of the result fields in m_tdata.
    localparam int M_WF_BIT   = 0;
    localparam int M_OK_BIT   = 1;
    localparam int M_CALC_LSB = 2;
    localparam int M_RECV_LSB = 10;
    localparam int M_DATA_W   = 24;

    typedef struct packed {
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic       checksum_ok;
        logic       well_formed;
    } verdict_t;

    // Value of a hex digit in either case, or HEX_NONE for any other byte.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
                hex_value = d[4:0];
            end else if (c >= CH_UC_A && c <= CH_UC_F) begin
                d = c - CH_UC_A + 8'd10;
                hex_value = d[4:0];
            end else if (c >= CH_LC_A && c <= CH_LC_F) begin
                d = c - CH_LC_A + 8'd10;
                hex_value = d[4:0];
            end else begin
                hex_value = HEX_NONE;
            end
        end
    endfunction

endpackage

@@ rtl/core/nsv_scan.sv @@
// Per-sentence scanner: header, reserved character and checksum state,
// updated once per byte, with the verdict formed on the final byte.
// Depends on nsv_pkg.
module nsv_scan
    import nsv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] char_byte,
    input  logic       last_byte,
    output verdict_t   verdict
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             hdr_good_reg, hdr_good_next;
    logic             comma_reg, comma_next;
    logic             viol_reg, viol_next;
    logic             pend_reg, pend_next;
    logic [1:0]       after_reg, after_next;
    logic             dollar_reg, dollar_next;
    logic             star_reg, star_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       prev0_reg, prev1_reg;

    logic             reserved;
    logic [4:0]       hi_val, lo_val;
    logic             digits;
    logic [7:0]       recv;

    always_comb begin
        reserved      = (char_byte == CH_STAR) || (char_byte == CH_DOLLAR);
        hdr_good_next = hdr_good_reg;
        case (pos_reg)
            4'd0: if (char_byte != CH_DOLLAR) hdr_good_next = 1'b0;
            4'd1: if (char_byte != CH_G) hdr_good_next = 1'b0;
            4'd2: if (char_byte != CH_P) hdr_good_next = 1'b0;
            4'd3, 4'd4, 4'd5: begin
                if (char_byte < CH_UC_A || char_byte > CH_UC_Z) hdr_good_next = 1'b0;
            end
            default: ;
        endcase
        pos_next = (pos_reg < POS_FULL) ? pos_reg + 1'b1 : pos_reg;

        // An asterisk or dollar after the first comma must be followed by
        // exactly two more bytes and nothing else reserved.
        viol_next  = viol_reg;
        pend_next  = pend_reg;
        after_next = after_reg;
        if (comma_reg && reserved) begin
            if (pend_reg) viol_next = 1'b1;
            pend_next  = 1'b1;
            after_next = 2'd0;
        end else if (pend_reg) begin
            if (after_reg >= 2'd2) begin
                viol_next  = 1'b1;
                pend_next  = 1'b0;
                after_next = 2'd0;
            end else begin
                after_next = after_reg + 1'b1;
            end
        end
        comma_next = comma_reg || (char_byte == CH_COMMA);

        star_next   = star_reg;
        dollar_next = dollar_reg;
        xor_next    = xor_reg;
        if (!star_reg) begin
            if (char_byte == CH_STAR) begin
                star_next = 1'b1;
            end else if (char_byte == CH_DOLLAR && !dollar_reg) begin
                dollar_next = 1'b1;
                xor_next    = 8'd0;
            end else begin
                xor_next = xor_reg ^ char_byte;
            end
        end else if (char_byte == CH_DOLLAR && !dollar_reg) begin
            dollar_next = 1'b1;
            xor_next    = 8'd0;
        end

        hi_val = hex_value(prev0_reg);
        lo_val = hex_value(char_byte);
        digits = (hi_val != HEX_NONE) && (lo_val != HEX_NONE);
        recv   = digits ? {hi_val[3:0], lo_val[3:0]} : 8'd0;

        verdict.well_formed  = hdr_good_next && (prev1_reg == CH_STAR) && digits
                               && (pos_next >= POS_FULL) && !viol_next;
        verdict.checksum_ok  = star_next && digits && (recv == xor_next);
        verdict.computed_sum = xor_next;
        verdict.received_sum = recv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            pos_reg      <= '0;
            hdr_good_reg <= 1'b1;
            comma_reg    <= 1'b0;
            viol_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            after_reg    <= 2'd0;
            dollar_reg   <= 1'b0;
            star_reg     <= 1'b0;
            xor_reg      <= 8'd0;
            prev0_reg    <= 8'd0;
            prev1_reg    <= 8'd0;
        end else if (step) begin
            pos_reg      <= pos_next;
            hdr_good_reg <= hdr_good_next;
            comma_reg    <= comma_next;
            viol_reg     <= viol_next;
            pend_reg     <= pend_next;
            after_reg    <= after_next;
            dollar_reg   <= dollar_next;
            star_reg     <= star_next;
            xor_reg      <= xor_next;
            prev0_reg    <= char_byte;
            prev1_reg    <= prev0_reg;
        end
    end

endmodule

@@ rtl/core/nmea_sentence_validator.sv @@
// Top level of the sentence validator: input register, scanner and
// result register with stream handshakes. Depends on nsv_pkg and nsv_scan.
//
//   channel | direction | payload
//   s_      | in        | tdata[7:0] char_byte, tlast last_byte
//   m_      | out       | tdata: well_formed, checksum_ok, computed_sum, received_sum
//
// One byte per cycle unless a held verdict stalls the input; the verdict is registered in
// the result register. The scanner updates its state when a registered byte advances.
// aresetn clears the sentence state, so the next byte starts a sentence.
// A held verdict stalls the input only when a further final byte arrives.
module nmea_sentence_validator
    import nsv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] char_byte
    input  logic                s_tlast,   // last_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [0] well_formed, [1] checksum_ok,
                                           // [9:2] computed_sum, [17:10] received_sum
);

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_vld_reg, out_vld_next;
    verdict_t   out_reg;
    verdict_t   verdict;
    logic       out_free;
    logic       advance;

    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    nsv_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .char_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .verdict   (verdict)
    );

    always_comb begin
        out_vld_next = out_vld_reg && !m_tready;
        if (advance && in_last_reg) out_vld_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) out_reg <= verdict;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_DATA_W - 18){1'b0}}, out_reg.received_sum,
                       out_reg.computed_sum, out_reg.checksum_ok, out_reg.well_formed};

endmodule

@@ rtl/core/nsv_checker.sv @@
// Port-level checks of the sentence validator, bound to its top level.
// Depends on nsv_pkg and nmea_sentence_validator_assert.svh.
`include "nmea_sentence_validator_assert.svh"

module nsv_checker
    import nsv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata
);

    logic out_stall;
    logic in_xfer_last;

    assign out_stall    = m_tvalid && !m_tready;
    assign in_xfer_last = s_tvalid && s_tready && s_tlast && (s_tdata != 8'd0 || 1'b1);

    `NSV_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid, "verdict dropped while stalled")
    `NSV_ASSERT_NEXT(a_out_stable, aclk, aresetn, out_stall, $stable(m_tdata), "verdict changed while stalled")
    `NSV_ASSERT_SAME(a_sum_match, aclk, aresetn, m_tvalid && m_tdata[M_OK_BIT], m_tdata[M_CALC_LSB +: 8] == m_tdata[M_RECV_LSB +: 8], "checksum_ok with differing sums")
    `NSV_ASSERT_NEXT(a_no_early, aclk, aresetn, !m_tvalid && !in_xfer_last, !m_tvalid || $past(s_tready), "verdict appeared with no final byte pending")

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (.*);
